[rtl/core/cmr_pkg.sv]
// shared word types and field widths for the cost matrix reduction block
package cmr_pkg;

   localparam int COST_W  = 16;
   localparam int INDEX_W = 2;
   localparam int BOUND_W = 19;

   typedef struct packed {
      logic [COST_W-1:0] entry_cost;
      logic              entry_blocked;
   } req_word_type;

   typedef struct packed {
      logic [INDEX_W-1:0] row_index;
      logic [INDEX_W-1:0] col_index;
      logic [COST_W-1:0]  reduced_cost;
      logic               reduced_blocked;
      logic [BOUND_W-1:0] bound_total;
      logic               last_entry;
   } rsp_word_type;

endpackage

[rtl/core/cost_matrix_row_column_reduction_top.sv]
// Reduced cost matrix lower bound: loads an N by N matrix, reduces rows then columns, emits it.
// A matrix is loaded one word per cycle while busy is low, MATRIX_DIM*MATRIX_DIM words in
// row-major order. After the last word busy rises and the block works out of a matrix memory
// with one write port and one registered read port: each row, then each column, is scanned
// for its minimum and then, unless it is wholly blocked, rewritten with the minimum
// subtracted. Finally the MATRIX_DIM*MATRIX_DIM reduced entries leave in row-major order,
// one per cycle with rsp_valid high for each; the receiver cannot stall them and must take
// every word.
module cost_matrix_row_column_reduction_top
   import cmr_pkg::*;
#(
   parameter int MATRIX_DIM = 4,
   parameter int COST_BITS  = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   localparam int CELLS      = MATRIX_DIM * MATRIX_DIM;
   localparam int IDX_BITS   = $clog2(MATRIX_DIM);
   localparam int POS_BITS   = $clog2(MATRIX_DIM + 1);
   localparam int ADDR_BITS  = $clog2(CELLS);
   localparam int BOUND_BITS = COST_BITS + $clog2(2 * MATRIX_DIM);

   typedef enum logic [5:0] {
      ST_LOAD     = 6'b000001,
      ST_ROW_SCAN = 6'b000010,
      ST_ROW_SUB  = 6'b000100,
      ST_COL_SCAN = 6'b001000,
      ST_COL_SUB  = 6'b010000,
      ST_EMIT     = 6'b100000
   } state_type;

   state_type               state_ff, state_in;
   logic [IDX_BITS-1:0]     line_ff, line_in;
   logic [POS_BITS-1:0]     pos_ff, pos_in;
   logic [ADDR_BITS-1:0]    load_cnt_ff, load_cnt_in;
   logic [COST_BITS-1:0]    min_ff, min_in;
   logic                    found_ff, found_in;
   logic [BOUND_BITS-1:0]   bound_ff, bound_in;
   logic                    rd_pend_ff, rd_pend_in;
   logic [ADDR_BITS-1:0]    rd_addr_ff;
   logic                    emit_ff, emit_in;
   logic [IDX_BITS-1:0]     out_row_ff, out_row_in;
   logic [IDX_BITS-1:0]     out_col_ff, out_col_in;
   logic                    out_last_ff, out_last_in;

   logic [COST_BITS:0]      mem [CELLS];
   logic [COST_BITS:0]      rdata_ff;
   logic                    mem_we;
   logic [ADDR_BITS-1:0]    mem_waddr;
   logic [COST_BITS:0]      mem_wdata;
   logic [ADDR_BITS-1:0]    mem_raddr;

   logic [IDX_BITS-1:0]     pos_idx;
   logic                    is_col;
   logic                    is_scan;
   logic                    is_sub;
   logic                    issue;
   logic [IDX_BITS-1:0]     row_sel;
   logic [IDX_BITS-1:0]     col_sel;
   logic [COST_BITS-1:0]    rd_cost;
   logic                    rd_blocked;
   logic                    last_line;

   logic [COST_BITS+COST_W-1:0]    in_wide;
   logic [COST_W+COST_BITS-1:0]    out_cost_wide;
   logic [BOUND_W+BOUND_BITS-1:0]  bound_wide;
   logic [INDEX_W+IDX_BITS-1:0]    row_wide;
   logic [INDEX_W+IDX_BITS-1:0]    col_wide;

   assign pos_idx    = pos_ff[IDX_BITS-1:0];
   assign is_col     = (state_ff == ST_COL_SCAN) || (state_ff == ST_COL_SUB);
   assign is_scan    = (state_ff == ST_ROW_SCAN) || (state_ff == ST_COL_SCAN);
   assign is_sub     = (state_ff == ST_ROW_SUB) || (state_ff == ST_COL_SUB);
   assign issue      = (is_scan || is_sub) && (pos_ff < POS_BITS'(MATRIX_DIM));
   assign row_sel    = is_col ? pos_idx : line_ff;
   assign col_sel    = is_col ? line_ff : pos_idx;
   assign mem_raddr  = ADDR_BITS'(row_sel) * ADDR_BITS'(MATRIX_DIM) + ADDR_BITS'(col_sel);
   assign rd_cost    = rdata_ff[COST_BITS-1:0];
   assign rd_blocked = rdata_ff[COST_BITS];
   assign last_line  = (line_ff == IDX_BITS'(MATRIX_DIM - 1));
   assign in_wide    = {{COST_BITS{1'b0}}, req_word.entry_cost};

   assign busy = (state_ff != ST_LOAD);

   always_comb begin
      state_in    = state_ff;
      line_in     = line_ff;
      pos_in      = pos_ff;
      load_cnt_in = load_cnt_ff;
      min_in      = min_ff;
      found_in    = found_ff;
      bound_in    = bound_ff;
      rd_pend_in  = issue;
      emit_in     = 1'b0;
      out_row_in  = out_row_ff;
      out_col_in  = out_col_ff;
      out_last_in = out_last_ff;
      mem_we      = 1'b0;
      mem_waddr   = rd_addr_ff;
      mem_wdata   = {1'b0, rd_cost - min_ff};

      case (state_ff)
         ST_LOAD: begin
            if (start) begin
               mem_we    = 1'b1;
               mem_waddr = load_cnt_ff;
               mem_wdata = {req_word.entry_blocked, in_wide[COST_BITS-1:0]};
               if (load_cnt_ff == ADDR_BITS'(CELLS - 1)) begin
                  load_cnt_in = '0;
                  state_in    = ST_ROW_SCAN;
                  line_in     = '0;
                  pos_in      = '0;
                  bound_in    = '0;
               end else begin
                  load_cnt_in = load_cnt_ff + 1'b1;
               end
            end
         end
         ST_ROW_SCAN, ST_COL_SCAN: begin
            if (pos_ff == '0) begin
               found_in = 1'b0;
            end
            if (rd_pend_ff && !rd_blocked && (!found_ff || rd_cost < min_ff)) begin
               min_in   = rd_cost;
               found_in = 1'b1;
            end
            if (issue) begin
               pos_in = pos_ff + 1'b1;
            end else begin
               pos_in = '0;
               if (found_in) begin
                  state_in = is_col ? ST_COL_SUB : ST_ROW_SUB;
               end else if (last_line) begin
                  line_in  = '0;
                  state_in = is_col ? ST_EMIT : ST_COL_SCAN;
               end else begin
                  line_in = line_ff + 1'b1;
               end
            end
         end
         ST_ROW_SUB, ST_COL_SUB: begin
            if (pos_ff == '0) begin
               bound_in = bound_ff + BOUND_BITS'(min_ff);
            end
            // write back the entry read last cycle, blocked ones stay as they are
            if (rd_pend_ff && !rd_blocked) begin
               mem_we = 1'b1;
            end
            if (issue) begin
               pos_in = pos_ff + 1'b1;
            end else begin
               pos_in = '0;
               if (last_line) begin
                  line_in  = '0;
                  state_in = is_col ? ST_EMIT : ST_COL_SCAN;
               end else begin
                  line_in  = line_ff + 1'b1;
                  state_in = is_col ? ST_COL_SCAN : ST_ROW_SCAN;
               end
            end
         end
         ST_EMIT: begin
            if (pos_ff < POS_BITS'(MATRIX_DIM)) begin
               emit_in     = 1'b1;
               out_row_in  = line_ff;
               out_col_in  = pos_idx;
               out_last_in = last_line && (pos_idx == IDX_BITS'(MATRIX_DIM - 1));
               if (pos_idx == IDX_BITS'(MATRIX_DIM - 1)) begin
                  if (last_line) begin
                     pos_in = POS_BITS'(MATRIX_DIM);
                  end else begin
                     pos_in  = '0;
                     line_in = line_ff + 1'b1;
                  end
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end else begin
               // last word is on the outputs this cycle
               pos_in   = '0;
               line_in  = '0;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         line_ff     <= '0;
         pos_ff      <= '0;
         load_cnt_ff <= '0;
         found_ff    <= 1'b0;
         bound_ff    <= '0;
         rd_pend_ff  <= 1'b0;
         emit_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         line_ff     <= line_in;
         pos_ff      <= pos_in;
         load_cnt_ff <= load_cnt_in;
         found_ff    <= found_in;
         bound_ff    <= bound_in;
         rd_pend_ff  <= rd_pend_in;
         emit_ff     <= emit_in;
      end
   end

   always_ff @(posedge clock) begin
      min_ff      <= min_in;
      rd_addr_ff  <= mem_raddr;
      out_row_ff  <= out_row_in;
      out_col_ff  <= out_col_in;
      out_last_ff <= out_last_in;
   end

   // matrix memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   assign out_cost_wide = {{COST_W{1'b0}}, rd_cost};
   assign bound_wide    = {{BOUND_W{1'b0}}, bound_ff};
   assign row_wide      = {{INDEX_W{1'b0}}, out_row_ff};
   assign col_wide      = {{INDEX_W{1'b0}}, out_col_ff};

   assign rsp_valid                = emit_ff;
   assign rsp_word.row_index       = row_wide[INDEX_W-1:0];
   assign rsp_word.col_index       = col_wide[INDEX_W-1:0];
   assign rsp_word.reduced_cost    = rd_blocked ? '0 : out_cost_wide[COST_W-1:0];
   assign rsp_word.reduced_blocked = rd_blocked;
   assign rsp_word.bound_total     = bound_wide[BOUND_W-1:0];
   assign rsp_word.last_entry      = out_last_ff;

endmodule

[dv/tb.sv]
// self-checking bench for the cost matrix row and column reduction block
module tb;
   import cmr_pkg::*;

   localparam int DIM = 4;
   localparam int CELLS = DIM * DIM;
   localparam int IDLE_PCT = 18;
   localparam int SETTLE_CYCLES = 2 * DIM * (2 * DIM + 2) + CELLS + 8;
   localparam int RANDOM_MATRICES = 13;
   localparam int MAX_REPORTS = 10;

   typedef enum int {
      MX_WIDE,
      MX_NARROW,
      MX_SPARSE,
      MX_ROW_OUT,
      MX_COL_OUT,
      MX_ALL_BLOCKED,
      MX_FLAT,
      MX_HIGH
   } matrix_kind_type;

   typedef struct {
      req_word_type word;
      bit           drain_first;
      bit           steady;
   } pending_word_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_word = '0;
   logic         rsp_valid;
   rsp_word_type rsp_word;

   pending_word_type  matrix_feed[$];
   rsp_word_type      reduced_queue[$];
   int unsigned       words_sent = 0;
   int unsigned       words_taken = 0;
   int unsigned       mismatch_count = 0;

   // shadow copy of the matrix memory
   logic [COST_W-1:0]  held_cost [CELLS];
   bit                 held_blocked [CELLS];
   int unsigned        load_count = 0;
   logic [BOUND_W:0]   bound_sum = '0;

   cost_matrix_row_column_reduction_top #(
      .MATRIX_DIM(DIM),
      .COST_BITS (COST_W)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_word (rsp_word)
   );

   always #5 clock = ~clock;

   function automatic void note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("mismatch: %s", msg);
      end
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got,
                                       rsp_word_type ref_word);
      if (want != got) begin
         note_mismatch($sformatf("row %0d col %0d %s expected %0h got %0h",
                                 ref_word.row_index, ref_word.col_index, name, want, got));
      end
   endfunction

   // subtract the minimum of one row or column over its unblocked entries
   function automatic void reduce_line(int first, int stride);
      logic [COST_W-1:0] lowest;
      bit                found;
      int                at;
      lowest = '0;
      found = 1'b0;
      for (int k = 0; k < DIM; k++) begin
         at = first + k * stride;
         if (!held_blocked[at] && (!found || held_cost[at] < lowest)) begin
            lowest = held_cost[at];
            found = 1'b1;
         end
      end
      if (found) begin
         bound_sum += lowest;
         for (int k = 0; k < DIM; k++) begin
            at = first + k * stride;
            if (!held_blocked[at]) begin
               held_cost[at] -= lowest;
            end
         end
      end
   endfunction

   function automatic void load_matrix_word(req_word_type w);
      rsp_word_type e;
      held_cost[load_count] = w.entry_cost;
      held_blocked[load_count] = w.entry_blocked;
      load_count++;
      if (load_count == CELLS) begin
         bound_sum = '0;
         for (int r = 0; r < DIM; r++) begin
            reduce_line(r * DIM, 1);
         end
         for (int c = 0; c < DIM; c++) begin
            reduce_line(c, DIM);
         end
         for (int at = 0; at < CELLS; at++) begin
            e.row_index = INDEX_W'(at / DIM);
            e.col_index = INDEX_W'(at % DIM);
            e.reduced_cost = held_blocked[at] ? '0 : held_cost[at];
            e.reduced_blocked = held_blocked[at];
            e.bound_total = bound_sum[BOUND_W-1:0];
            e.last_entry = (at == CELLS - 1);
            reduced_queue = {reduced_queue, e};
         end
         load_count = 0;
      end
   endfunction

   // accept words and check emitted entries
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset) begin
         if (start && !busy) begin
            load_matrix_word(req_word);
            words_taken <= words_taken + 1;
         end
         if (rsp_valid) begin
            if (reduced_queue.size() == 0) begin
               note_mismatch($sformatf("unexpected word %p", rsp_word));
            end else begin
               want = reduced_queue.pop_front();
               check_field("row_index", want.row_index, rsp_word.row_index, want);
               check_field("col_index", want.col_index, rsp_word.col_index, want);
               check_field("reduced_cost", want.reduced_cost, rsp_word.reduced_cost, want);
               check_field("reduced_blocked", want.reduced_blocked,
                           rsp_word.reduced_blocked, want);
               check_field("bound_total", want.bound_total, rsp_word.bound_total, want);
               check_field("last_entry", want.last_entry, rsp_word.last_entry, want);
            end
         end
      end
   end

   // present the next word once the previous one is taken
   always @(negedge clock) begin
      pending_word_type head;
      bit               hold;
      if (reset) begin
         start <= 1'b0;
      end else if (words_sent == words_taken) begin
         hold = 1'b1;
         if (matrix_feed.size() != 0) begin
            head = matrix_feed[0];
            hold = (head.drain_first && reduced_queue.size() != 0) ||
                   (!head.steady && $urandom_range(0, 99) < IDLE_PCT);
         end
         if (hold) begin
            start <= 1'b0;
         end else begin
            void'(matrix_feed.pop_front());
            start <= 1'b1;
            req_word <= head.word;
            words_sent <= words_sent + 1;
         end
      end
   end

   function automatic void add_word(logic [COST_W-1:0] cost, bit blocked, bit drain_first,
                                    bit steady);
      pending_word_type p;
      p.word.entry_cost = cost;
      p.word.entry_blocked = blocked;
      p.drain_first = drain_first;
      p.steady = steady;
      matrix_feed = {matrix_feed, p};
   endfunction

   function automatic void add_matrix(matrix_kind_type kind, bit drain_first, bit steady);
      int unsigned       line;
      logic [COST_W-1:0] flat;
      logic [COST_W-1:0] cost;
      bit                blocked;
      line = $urandom_range(0, DIM - 1);
      flat = COST_W'($urandom_range(0, 65535));
      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            cost = COST_W'($urandom_range(0, 65535));
            blocked = ($urandom_range(0, 9) == 0);
            case (kind)
               MX_NARROW: begin
                  cost = COST_W'($urandom_range(0, 15));
                  blocked = ($urandom_range(0, 5) == 0);
               end
               MX_SPARSE: blocked = ($urandom_range(0, 2) != 0);
               MX_ROW_OUT: blocked = blocked || (r == line);
               MX_COL_OUT: blocked = blocked || (c == line);
               MX_ALL_BLOCKED: blocked = 1'b1;
               MX_FLAT: begin
                  cost = flat;
                  blocked = 1'b0;
               end
               MX_HIGH: cost = COST_W'(65535 - $urandom_range(0, 15));
               default: ;
            endcase
            add_word(cost, blocked, drain_first && r == 0 && c == 0, steady);
         end
      end
   endfunction

   initial begin
      int unsigned       directed_cost [CELLS];
      bit [CELLS-1:0]    directed_blocked;
      matrix_kind_type   kind;

      // one row and one column wholly blocked, field extremes elsewhere
      directed_cost = '{
         65535, 0, 4660, 65535,
         65535, 0, 65535, 0,
         65535, 65534, 65535, 1,
         43690, 21845, 1, 0
      };
      directed_blocked = 16'b1000_1000_1111_1000;

      for (int at = 0; at < CELLS; at++) begin
         add_word(COST_W'(directed_cost[at]), directed_blocked[CELLS-1-at], 1'b0, 1'b0);
      end
      for (int i = 0; i < RANDOM_MATRICES; i++) begin
         if (i <= MX_HIGH) begin
            kind = matrix_kind_type'(i);
         end else begin
            kind = matrix_kind_type'($urandom_range(0, MX_HIGH));
         end
         // pause for a full drain before a couple of matrices, no idling over three
         add_matrix(kind, i == 0 || i == 6, i >= 3 && i <= 5);
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (matrix_feed.size() != 0 || words_sent != words_taken) begin
         @(posedge clock);
      end
      while (reduced_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
